### rtl/assert_macros.svh
// Assertion helpers shared by the RTL. Empty when synthesising.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// prop must hold at every edge out of reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg)
`define ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/clst_pkg.sv
package clst_pkg;

    // instruction class
    typedef enum logic [3:0] {
        K_BAD,
        K_LDA,
        K_LDX,
        K_LDY,
        K_STA,
        K_STX,
        K_STY,
        K_TAX,
        K_TAY,
        K_TXA,
        K_TYA,
        K_TSX,
        K_TXS,
        K_NOP
    } t_kind;

    // addressing mode
    typedef enum logic [3:0] {
        M_IMP,
        M_IMD,
        M_ZP,
        M_ZPX,
        M_ZPY,
        M_ABS,
        M_ABSX,
        M_ABSY,
        M_INDX,
        M_INDY
    } t_mode;

    typedef struct packed {
        t_kind kind;
        t_mode mode;
    } t_dec;

    // configuration register indexes
    localparam logic CFG_START_PC  = 1'b0;
    localparam logic CFG_UNDEF_NOP = 1'b1;

    // N and Z live at bits 7 and 1; everything else is kept
    localparam logic [7:0] FLAGS_KEEP_MASK = 8'h7D;

    function automatic logic [7:0] f_set_nz(input logic [7:0] flags, input logic [7:0] v);
        return (flags & FLAGS_KEEP_MASK) | {v[7], 5'b00000, (v == 8'h00), 1'b0};
    endfunction

endpackage

### rtl/clst_decode.sv
module clst_decode
    import clst_pkg::*;
(
    input  logic [7:0] i_opcode,
    output t_dec       o_dec
);

    localparam logic [7:0] OP_STA_INDX = 8'h81;
    localparam logic [7:0] OP_STY_ZP   = 8'h84;
    localparam logic [7:0] OP_STA_ZP   = 8'h85;
    localparam logic [7:0] OP_STX_ZP   = 8'h86;
    localparam logic [7:0] OP_TXA      = 8'h8A;
    localparam logic [7:0] OP_STY_ABS  = 8'h8C;
    localparam logic [7:0] OP_STA_ABS  = 8'h8D;
    localparam logic [7:0] OP_STX_ABS  = 8'h8E;
    localparam logic [7:0] OP_STA_INDY = 8'h91;
    localparam logic [7:0] OP_STY_ZPX  = 8'h94;
    localparam logic [7:0] OP_STA_ZPX  = 8'h95;
    localparam logic [7:0] OP_STX_ZPY  = 8'h96;
    localparam logic [7:0] OP_TYA      = 8'h98;
    localparam logic [7:0] OP_STA_ABSY = 8'h99;
    localparam logic [7:0] OP_TXS      = 8'h9A;
    localparam logic [7:0] OP_STA_ABSX = 8'h9D;
    localparam logic [7:0] OP_LDY_IMD  = 8'hA0;
    localparam logic [7:0] OP_LDA_INDX = 8'hA1;
    localparam logic [7:0] OP_LDX_IMD  = 8'hA2;
    localparam logic [7:0] OP_LDY_ZP   = 8'hA4;
    localparam logic [7:0] OP_LDA_ZP   = 8'hA5;
    localparam logic [7:0] OP_LDX_ZP   = 8'hA6;
    localparam logic [7:0] OP_TAY      = 8'hA8;
    localparam logic [7:0] OP_LDA_IMD  = 8'hA9;
    localparam logic [7:0] OP_TAX      = 8'hAA;
    localparam logic [7:0] OP_LDY_ABS  = 8'hAC;
    localparam logic [7:0] OP_LDA_ABS  = 8'hAD;
    localparam logic [7:0] OP_LDX_ABS  = 8'hAE;
    localparam logic [7:0] OP_LDA_INDY = 8'hB1;
    localparam logic [7:0] OP_LDY_ZPX  = 8'hB4;
    localparam logic [7:0] OP_LDA_ZPX  = 8'hB5;
    localparam logic [7:0] OP_LDX_ZPY  = 8'hB6;
    localparam logic [7:0] OP_LDA_ABSY = 8'hB9;
    localparam logic [7:0] OP_TSX      = 8'hBA;
    localparam logic [7:0] OP_LDY_ABSX = 8'hBC;
    localparam logic [7:0] OP_LDA_ABSX = 8'hBD;
    localparam logic [7:0] OP_LDX_ABSY = 8'hBE;

    always_comb begin
        unique case (i_opcode)
            OP_STA_INDX: o_dec = '{K_STA, M_INDX};
            OP_STY_ZP:   o_dec = '{K_STY, M_ZP};
            OP_STA_ZP:   o_dec = '{K_STA, M_ZP};
            OP_STX_ZP:   o_dec = '{K_STX, M_ZP};
            OP_TXA:      o_dec = '{K_TXA, M_IMP};
            OP_STY_ABS:  o_dec = '{K_STY, M_ABS};
            OP_STA_ABS:  o_dec = '{K_STA, M_ABS};
            OP_STX_ABS:  o_dec = '{K_STX, M_ABS};
            OP_STA_INDY: o_dec = '{K_STA, M_INDY};
            OP_STY_ZPX:  o_dec = '{K_STY, M_ZPX};
            OP_STA_ZPX:  o_dec = '{K_STA, M_ZPX};
            OP_STX_ZPY:  o_dec = '{K_STX, M_ZPY};
            OP_TYA:      o_dec = '{K_TYA, M_IMP};
            OP_STA_ABSY: o_dec = '{K_STA, M_ABSY};
            OP_TXS:      o_dec = '{K_TXS, M_IMP};
            OP_STA_ABSX: o_dec = '{K_STA, M_ABSX};
            OP_LDY_IMD:  o_dec = '{K_LDY, M_IMD};
            OP_LDA_INDX: o_dec = '{K_LDA, M_INDX};
            OP_LDX_IMD:  o_dec = '{K_LDX, M_IMD};
            OP_LDY_ZP:   o_dec = '{K_LDY, M_ZP};
            OP_LDA_ZP:   o_dec = '{K_LDA, M_ZP};
            OP_LDX_ZP:   o_dec = '{K_LDX, M_ZP};
            OP_TAY:      o_dec = '{K_TAY, M_IMP};
            OP_LDA_IMD:  o_dec = '{K_LDA, M_IMD};
            OP_TAX:      o_dec = '{K_TAX, M_IMP};
            OP_LDY_ABS:  o_dec = '{K_LDY, M_ABS};
            OP_LDA_ABS:  o_dec = '{K_LDA, M_ABS};
            OP_LDX_ABS:  o_dec = '{K_LDX, M_ABS};
            OP_LDA_INDY: o_dec = '{K_LDA, M_INDY};
            OP_LDY_ZPX:  o_dec = '{K_LDY, M_ZPX};
            OP_LDA_ZPX:  o_dec = '{K_LDA, M_ZPX};
            OP_LDX_ZPY:  o_dec = '{K_LDX, M_ZPY};
            OP_LDA_ABSY: o_dec = '{K_LDA, M_ABSY};
            OP_TSX:      o_dec = '{K_TSX, M_IMP};
            OP_LDY_ABSX: o_dec = '{K_LDY, M_ABSX};
            OP_LDA_ABSX: o_dec = '{K_LDA, M_ABSX};
            OP_LDX_ABSY: o_dec = '{K_LDX, M_ABSY};
            default:     o_dec = '{K_BAD, M_IMP};
        endcase
    end

endmodule

### rtl/cpu_load_store_transfer_core.sv
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+--------------------------------------
// in       | to core   | i_in_valid / o_in_stall    | i_read_data
// out      | from core | o_out_valid / i_out_stall  | bus request + visible registers
// cfg      | to core   | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item (a completed bus cycle) in, one item (the next bus request) out.
// Decode, address add and register update sit between the architectural
// state and the output register, so an item may be accepted on every clock
// while the out side does not stall. o_out_valid rises in the cycle after accept.
// Reset (i_rst_n low, synchronous) clears all registers but the output payload;
// the first item after reset loads the PC from start_pc and fetches the first opcode.
// A stall on the out side holds the output register and back-pressures the in
// side in the same cycle; the cfg port never stalls.
`include "assert_macros.svh"

module cpu_load_store_transfer_core
    import clst_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data,

    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_read_data,

    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_bus_address,
    output logic        o_bus_write,
    output logic [7:0]  o_bus_write_data,
    output logic        o_instr_done,
    output logic        o_fault,
    output logic [7:0]  o_acc_out,
    output logic [7:0]  o_x_out,
    output logic [7:0]  o_y_out,
    output logic [7:0]  o_sp_out,
    output logic [7:0]  o_flags_out,
    output logic [15:0] o_pc_out
);

    // bus-cycle phase: what the incoming read data means
    localparam logic [2:0] PH_START   = 3'd0;  // nothing fetched yet
    localparam logic [2:0] PH_OPCODE  = 3'd1;  // opcode arriving
    localparam logic [2:0] PH_OPER1   = 3'd2;  // first operand byte arriving
    localparam logic [2:0] PH_OPER2   = 3'd3;  // second byte / pointer low arriving
    localparam logic [2:0] PH_PTRHI   = 3'd4;  // pointer high byte arriving
    localparam logic [2:0] PH_WRITTEN = 3'd5;  // store just done
    localparam logic [2:0] PH_LOAD    = 3'd6;  // load data arriving
    localparam logic [2:0] PH_HALT    = 3'd7;  // faulted, frozen until reset

    // configuration
    logic [15:0] r_start_pc;
    logic        r_undef_nop;

    // architectural and sequencing state
    logic [15:0] r_pc,    n_pc;
    logic [7:0]  r_acc,   n_acc;
    logic [7:0]  r_x,     n_x;
    logic [7:0]  r_y,     n_y;
    logic [7:0]  r_sp,    n_sp;
    logic [7:0]  r_flags, n_flags;
    logic [2:0]  r_phase, n_phase;
    t_kind       r_kind,  n_kind;
    t_mode       r_mode,  n_mode;
    logic [7:0]  r_ptr,   n_ptr;     // zp pointer / absolute low byte
    logic [7:0]  r_eff_lo, n_eff_lo; // indirect target low byte
    logic        r_fault, n_fault;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_addr,  n_out_addr;
    logic        r_out_wr,    n_out_wr;
    logic [7:0]  r_out_wd,    n_out_wd;
    logic        r_out_done,  n_out_done;

    logic        w_in_acc;
    t_dec        w_dec;
    t_kind       w_kind;
    logic        w_go;        // start the data access this cycle
    logic [15:0] w_go_addr;
    logic [7:0]  w_index;
    logic [15:0] w_sum;

    clst_decode u_decode (
        .i_opcode (i_read_data),
        .o_dec    (w_dec)
    );

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid && i_out_stall;
    assign w_in_acc    = i_in_valid && !o_in_stall;

    // undefined opcodes run as NOP when enabled
    assign w_kind = (w_dec.kind == K_BAD && r_undef_nop) ? K_NOP : w_dec.kind;

    // one shared 16-bit adder: absolute/indirect base plus index
    always_comb begin
        w_index = 8'h00;
        if (r_phase == PH_OPER2 && r_mode == M_ABSX) begin
            w_index = r_x;
        end else if ((r_phase == PH_OPER2 && r_mode == M_ABSY)
                     || (r_phase == PH_PTRHI && r_mode == M_INDY)) begin
            w_index = r_y;
        end
        w_sum = {i_read_data, (r_phase == PH_PTRHI) ? r_eff_lo : r_ptr} + {8'h00, w_index};
    end

    always_comb begin
        n_pc       = r_pc;
        n_acc      = r_acc;
        n_x        = r_x;
        n_y        = r_y;
        n_sp       = r_sp;
        n_flags    = r_flags;
        n_phase    = r_phase;
        n_kind     = r_kind;
        n_mode     = r_mode;
        n_ptr      = r_ptr;
        n_eff_lo   = r_eff_lo;
        n_fault    = r_fault;
        n_out_addr = r_pc;
        n_out_wr   = 1'b0;
        n_out_wd   = 8'h00;
        n_out_done = 1'b0;
        w_go       = 1'b0;
        w_go_addr  = 16'h0000;

        unique case (r_phase)
            PH_START: begin
                n_out_addr = r_start_pc;
                n_out_done = 1'b1;
                n_pc       = r_start_pc + 16'd1;
                n_phase    = PH_OPCODE;
            end
            PH_OPCODE: begin
                n_kind = w_kind;
                n_mode = w_dec.mode;
                if (w_kind == K_BAD) begin
                    n_fault = 1'b1;
                    n_phase = PH_HALT;
                end else if (w_dec.mode == M_IMP) begin
                    unique case (w_kind)
                        K_TAX: begin
                            n_x     = r_acc;
                            n_flags = f_set_nz(r_flags, r_acc);
                        end
                        K_TAY: begin
                            n_y     = r_acc;
                            n_flags = f_set_nz(r_flags, r_acc);
                        end
                        K_TXA: begin
                            n_acc   = r_x;
                            n_flags = f_set_nz(r_flags, r_x);
                        end
                        K_TYA: begin
                            n_acc   = r_y;
                            n_flags = f_set_nz(r_flags, r_y);
                        end
                        K_TSX: begin
                            n_x     = r_sp;
                            n_flags = f_set_nz(r_flags, r_sp);
                        end
                        K_TXS: n_sp = r_x;
                        default: ;
                    endcase
                    n_out_done = 1'b1;
                    n_pc       = r_pc + 16'd1;
                end else begin
                    // fetch the operand byte
                    n_pc    = r_pc + 16'd1;
                    n_phase = (w_dec.mode == M_IMD) ? PH_LOAD : PH_OPER1;
                end
            end
            PH_OPER1: begin
                unique case (r_mode)
                    M_ZP: begin
                        w_go      = 1'b1;
                        w_go_addr = {8'h00, i_read_data};
                    end
                    M_ZPX: begin
                        w_go      = 1'b1;
                        w_go_addr = {8'h00, i_read_data + r_x};
                    end
                    M_ZPY: begin
                        w_go      = 1'b1;
                        w_go_addr = {8'h00, i_read_data + r_y};
                    end
                    M_ABS, M_ABSX, M_ABSY: begin
                        n_ptr   = i_read_data;
                        n_pc    = r_pc + 16'd1;
                        n_phase = PH_OPER2;
                    end
                    M_INDX: begin
                        n_ptr      = i_read_data + r_x;
                        n_out_addr = {8'h00, i_read_data + r_x};
                        n_phase    = PH_OPER2;
                    end
                    M_INDY: begin
                        n_ptr      = i_read_data;
                        n_out_addr = {8'h00, i_read_data};
                        n_phase    = PH_OPER2;
                    end
                    default: begin
                        n_out_done = 1'b1;
                        n_pc       = r_pc + 16'd1;
                        n_phase    = PH_OPCODE;
                    end
                endcase
            end
            PH_OPER2: begin
                if (r_mode == M_INDX || r_mode == M_INDY) begin
                    // pointer high byte wraps within page zero
                    n_eff_lo   = i_read_data;
                    n_out_addr = {8'h00, r_ptr + 8'd1};
                    n_phase    = PH_PTRHI;
                end else begin
                    w_go      = 1'b1;
                    w_go_addr = w_sum;
                end
            end
            PH_PTRHI: begin
                w_go      = 1'b1;
                w_go_addr = w_sum;
            end
            PH_WRITTEN: begin
                n_out_done = 1'b1;
                n_pc       = r_pc + 16'd1;
                n_phase    = PH_OPCODE;
            end
            PH_LOAD: begin
                unique case (r_kind)
                    K_LDA: begin
                        n_acc   = i_read_data;
                        n_flags = f_set_nz(r_flags, i_read_data);
                    end
                    K_LDX: begin
                        n_x     = i_read_data;
                        n_flags = f_set_nz(r_flags, i_read_data);
                    end
                    K_LDY: begin
                        n_y     = i_read_data;
                        n_flags = f_set_nz(r_flags, i_read_data);
                    end
                    default: ;
                endcase
                n_out_done = 1'b1;
                n_pc       = r_pc + 16'd1;
                n_phase    = PH_OPCODE;
            end
            PH_HALT: ;
            default: ;
        endcase

        // data access: stores write straight away, loads wait for the byte
        if (w_go) begin
            n_out_addr = w_go_addr;
            if (r_kind == K_STA || r_kind == K_STX || r_kind == K_STY) begin
                n_out_wr = 1'b1;
                n_out_wd = (r_kind == K_STA) ? r_acc : (r_kind == K_STX) ? r_x : r_y;
                n_phase  = PH_WRITTEN;
            end else begin
                n_phase  = PH_LOAD;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_pc  <= 16'h0000;
            r_undef_nop <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_START_PC:  r_start_pc  <= i_cfg_data;
                CFG_UNDEF_NOP: r_undef_nop <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc        <= 16'h0000;
            r_acc       <= 8'h00;
            r_x         <= 8'h00;
            r_y         <= 8'h00;
            r_sp        <= 8'h00;
            r_flags     <= 8'h00;
            r_phase     <= PH_START;
            r_kind      <= K_BAD;
            r_mode      <= M_IMP;
            r_ptr       <= 8'h00;
            r_eff_lo    <= 8'h00;
            r_fault     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_acc) begin
                r_pc     <= n_pc;
                r_acc    <= n_acc;
                r_x      <= n_x;
                r_y      <= n_y;
                r_sp     <= n_sp;
                r_flags  <= n_flags;
                r_phase  <= n_phase;
                r_kind   <= n_kind;
                r_mode   <= n_mode;
                r_ptr    <= n_ptr;
                r_eff_lo <= n_eff_lo;
                r_fault  <= n_fault;
            end
            if (w_in_acc) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload; registers copied alongside the bus request
    logic [7:0]  r_out_acc, r_out_x, r_out_y, r_out_sp, r_out_flags;
    logic [15:0] r_out_pc;
    logic        r_out_fault;

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_addr  <= n_out_addr;
            r_out_wr    <= n_out_wr;
            r_out_wd    <= n_out_wd;
            r_out_done  <= n_out_done;
            r_out_fault <= n_fault;
            r_out_acc   <= n_acc;
            r_out_x     <= n_x;
            r_out_y     <= n_y;
            r_out_sp    <= n_sp;
            r_out_flags <= n_flags;
            r_out_pc    <= n_pc;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_bus_address    = r_out_addr;
    assign o_bus_write      = r_out_wr;
    assign o_bus_write_data = r_out_wd;
    assign o_instr_done     = r_out_done;
    assign o_fault          = r_out_fault;
    assign o_acc_out        = r_out_acc;
    assign o_x_out          = r_out_x;
    assign o_y_out          = r_out_y;
    assign o_sp_out         = r_out_sp;
    assign o_flags_out      = r_out_flags;
    assign o_pc_out         = r_out_pc;

    `ASSERT_IMPLIES(a_halt_has_fault, i_clk, i_rst_n, r_phase == PH_HALT, r_fault, "halted without fault")
    `ASSERT_NEXT(a_fault_sticky, i_clk, i_rst_n, r_fault, r_fault, "fault cleared without reset")
    `ASSERT_IMPLIES(a_write_not_fetch, i_clk, i_rst_n, r_out_valid && r_out_wr, !r_out_done, "store marked as opcode fetch")
    `ASSERT_NEXT(a_store_then_written, i_clk, i_rst_n, w_in_acc && n_out_wr, r_phase == PH_WRITTEN && o_bus_write, "store did not enter written phase")
    `ASSERT_NEXT(a_halt_quiet, i_clk, i_rst_n, w_in_acc && r_phase == PH_HALT, o_out_valid && o_fault && !o_bus_write && !o_instr_done, "halted core issued activity")

endmodule

### verif/tb_top.sv
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import clst_pkg::*;

    // Opcodes the core knows
    localparam logic [7:0] OP_STA_INDX = 8'h81, OP_STY_ZP   = 8'h84, OP_STA_ZP   = 8'h85;
    localparam logic [7:0] OP_STX_ZP   = 8'h86, OP_TXA      = 8'h8A, OP_STY_ABS  = 8'h8C;
    localparam logic [7:0] OP_STA_ABS  = 8'h8D, OP_STX_ABS  = 8'h8E, OP_STA_INDY = 8'h91;
    localparam logic [7:0] OP_STY_ZPX  = 8'h94, OP_STA_ZPX  = 8'h95, OP_STX_ZPY  = 8'h96;
    localparam logic [7:0] OP_TYA      = 8'h98, OP_STA_ABSY = 8'h99, OP_TXS      = 8'h9A;
    localparam logic [7:0] OP_STA_ABSX = 8'h9D, OP_LDY_IMM  = 8'hA0, OP_LDA_INDX = 8'hA1;
    localparam logic [7:0] OP_LDX_IMM  = 8'hA2, OP_LDY_ZP   = 8'hA4, OP_LDA_ZP   = 8'hA5;
    localparam logic [7:0] OP_LDX_ZP   = 8'hA6, OP_TAY      = 8'hA8, OP_LDA_IMM  = 8'hA9;
    localparam logic [7:0] OP_TAX      = 8'hAA, OP_LDY_ABS  = 8'hAC, OP_LDA_ABS  = 8'hAD;
    localparam logic [7:0] OP_LDX_ABS  = 8'hAE, OP_LDA_INDY = 8'hB1, OP_LDY_ZPX  = 8'hB4;
    localparam logic [7:0] OP_LDA_ZPX  = 8'hB5, OP_LDX_ZPY  = 8'hB6, OP_LDA_ABSY = 8'hB9;
    localparam logic [7:0] OP_TSX      = 8'hBA, OP_LDY_ABSX = 8'hBC, OP_LDA_ABSX = 8'hBD;
    localparam logic [7:0] OP_LDX_ABSY = 8'hBE;
    // Opcodes outside the subset: BRK, compare, the official NOP and an unused slot
    localparam logic [7:0] OP_BRK = 8'h00, OP_CMP_IMM = 8'hC9, OP_NOP = 8'hEA;
    localparam logic [7:0] OP_UNUSED_FF = 8'hFF;

    localparam logic [7:0] NZ_BITS = 8'h82;

    // Where the core is within an instruction
    typedef enum logic [2:0] {
        PH_BOOT, PH_OPCODE, PH_OPER1, PH_OPER2, PH_PTR_HI, PH_WROTE, PH_LOAD, PH_HALT
    } t_phase;

    // One bus request plus the visible registers
    typedef struct packed {
        logic [15:0] addr;
        logic        wr;
        logic [7:0]  wdata;
        logic        done;
        logic        fault;
        logic [7:0]  acc;
        logic [7:0]  xr;
        logic [7:0]  yr;
        logic [7:0]  sp;
        logic [7:0]  flags;
        logic [15:0] pc;
    } t_bus_cycle;

    // Shadow CPU: steps one bus cycle per accepted item and queues the bus request
    // the core must issue next.
    class core_scoreboard;
        logic [15:0] start_pc;
        logic        undef_nop;
        logic [15:0] pc, eff;
        logic [7:0]  acc, xr, yr, sp, flags, opcode, ptr_lo;
        logic        faulted;
        t_phase      ph;
        t_bus_cycle  pending[$];
        int          errors;

        function new();
            start_pc = '0;
            undef_nop = 1'b0;
            pc = '0;
            eff = '0;
            {acc, xr, yr, sp, flags, opcode, ptr_lo} = '0;
            faulted = 1'b0;
            ph = PH_BOOT;
            errors = 0;
        endfunction

        function t_dec decode(input logic [7:0] op);
            t_dec dec;
            dec = '{K_BAD, M_IMP};
            case (op)
                OP_STA_INDX: dec = '{K_STA, M_INDX};
                OP_STY_ZP:   dec = '{K_STY, M_ZP};
                OP_STA_ZP:   dec = '{K_STA, M_ZP};
                OP_STX_ZP:   dec = '{K_STX, M_ZP};
                OP_TXA:      dec = '{K_TXA, M_IMP};
                OP_STY_ABS:  dec = '{K_STY, M_ABS};
                OP_STA_ABS:  dec = '{K_STA, M_ABS};
                OP_STX_ABS:  dec = '{K_STX, M_ABS};
                OP_STA_INDY: dec = '{K_STA, M_INDY};
                OP_STY_ZPX:  dec = '{K_STY, M_ZPX};
                OP_STA_ZPX:  dec = '{K_STA, M_ZPX};
                OP_STX_ZPY:  dec = '{K_STX, M_ZPY};
                OP_TYA:      dec = '{K_TYA, M_IMP};
                OP_STA_ABSY: dec = '{K_STA, M_ABSY};
                OP_TXS:      dec = '{K_TXS, M_IMP};
                OP_STA_ABSX: dec = '{K_STA, M_ABSX};
                OP_LDY_IMM:  dec = '{K_LDY, M_IMD};
                OP_LDA_INDX: dec = '{K_LDA, M_INDX};
                OP_LDX_IMM:  dec = '{K_LDX, M_IMD};
                OP_LDY_ZP:   dec = '{K_LDY, M_ZP};
                OP_LDA_ZP:   dec = '{K_LDA, M_ZP};
                OP_LDX_ZP:   dec = '{K_LDX, M_ZP};
                OP_TAY:      dec = '{K_TAY, M_IMP};
                OP_LDA_IMM:  dec = '{K_LDA, M_IMD};
                OP_TAX:      dec = '{K_TAX, M_IMP};
                OP_LDY_ABS:  dec = '{K_LDY, M_ABS};
                OP_LDA_ABS:  dec = '{K_LDA, M_ABS};
                OP_LDX_ABS:  dec = '{K_LDX, M_ABS};
                OP_LDA_INDY: dec = '{K_LDA, M_INDY};
                OP_LDY_ZPX:  dec = '{K_LDY, M_ZPX};
                OP_LDA_ZPX:  dec = '{K_LDA, M_ZPX};
                OP_LDX_ZPY:  dec = '{K_LDX, M_ZPY};
                OP_LDA_ABSY: dec = '{K_LDA, M_ABSY};
                OP_TSX:      dec = '{K_TSX, M_IMP};
                OP_LDY_ABSX: dec = '{K_LDY, M_ABSX};
                OP_LDA_ABSX: dec = '{K_LDA, M_ABSX};
                OP_LDX_ABSY: dec = '{K_LDX, M_ABSY};
                default:     dec = '{K_BAD, M_IMP};
            endcase
            return dec;
        endfunction

        function logic [7:0] nz(input logic [7:0] v);
            flags = (flags & ~NZ_BITS) | {v[7], 5'b00000, (v == 8'h00), 1'b0};
            return v;
        endfunction

        function void fetch(inout t_bus_cycle r);
            r.addr = pc;
            r.done = 1'b1;
            pc = pc + 16'd1;
            ph = PH_OPCODE;
        endfunction

        function void access(input t_kind k, input logic [15:0] ad, inout t_bus_cycle r);
            eff = ad;
            r.addr = ad;
            if (k == K_STA || k == K_STX || k == K_STY) begin
                r.wr = 1'b1;
                r.wdata = (k == K_STA) ? acc : (k == K_STX) ? xr : yr;
                ph = PH_WROTE;
            end else begin
                ph = PH_LOAD;
            end
        endfunction

        function t_bus_cycle step(input logic [7:0] rd);
            t_bus_cycle  r;
            t_dec        d;
            logic [15:0] base;
            logic [7:0]  zp;
            r = '0;
            r.addr = pc;
            d = decode(opcode);
            case (ph)
                PH_BOOT: begin
                    pc = start_pc;
                    fetch(r);
                end
                PH_OPCODE: begin
                    opcode = rd;
                    d = decode(rd);
                    if (d.kind == K_BAD && !undef_nop) begin
                        faulted = 1'b1;
                        ph = PH_HALT;
                    end else if (d.mode == M_IMP) begin
                        // undefined opcodes land here as NOP and change nothing
                        case (d.kind)
                            K_TAX:   xr = nz(acc);
                            K_TAY:   yr = nz(acc);
                            K_TXA:   acc = nz(xr);
                            K_TYA:   acc = nz(yr);
                            K_TSX:   xr = nz(sp);
                            K_TXS:   sp = xr;
                            default: ;
                        endcase
                        fetch(r);
                    end else begin
                        r.addr = pc;
                        pc = pc + 16'd1;
                        if (d.mode == M_IMD) begin
                            eff = r.addr;
                            ph = PH_LOAD;
                        end else begin
                            ph = PH_OPER1;
                        end
                    end
                end
                PH_OPER1: begin
                    case (d.mode)
                        M_ZP: access(d.kind, {8'h00, rd}, r);
                        M_ZPX: begin
                            zp = rd + xr;
                            access(d.kind, {8'h00, zp}, r);
                        end
                        M_ZPY: begin
                            zp = rd + yr;
                            access(d.kind, {8'h00, zp}, r);
                        end
                        M_ABS, M_ABSX, M_ABSY: begin
                            ptr_lo = rd;
                            r.addr = pc;
                            pc = pc + 16'd1;
                            ph = PH_OPER2;
                        end
                        M_INDX: begin
                            ptr_lo = rd + xr;
                            r.addr = {8'h00, ptr_lo};
                            ph = PH_OPER2;
                        end
                        M_INDY: begin
                            ptr_lo = rd;
                            r.addr = {8'h00, rd};
                            ph = PH_OPER2;
                        end
                        default: fetch(r);
                    endcase
                end
                PH_OPER2: begin
                    if (d.mode == M_INDX || d.mode == M_INDY) begin
                        eff = {8'h00, rd};
                        zp = ptr_lo + 8'd1;
                        r.addr = {8'h00, zp};
                        ph = PH_PTR_HI;
                    end else begin
                        base = {rd, ptr_lo};
                        if (d.mode == M_ABSX) begin
                            base = base + {8'h00, xr};
                        end else if (d.mode == M_ABSY) begin
                            base = base + {8'h00, yr};
                        end
                        access(d.kind, base, r);
                    end
                end
                PH_PTR_HI: begin
                    base = {rd, eff[7:0]};
                    if (d.mode == M_INDY) begin
                        base = base + {8'h00, yr};
                    end
                    access(d.kind, base, r);
                end
                PH_WROTE: fetch(r);
                PH_LOAD: begin
                    case (d.kind)
                        K_LDA:   acc = nz(rd);
                        K_LDX:   xr = nz(rd);
                        K_LDY:   yr = nz(rd);
                        default: ;
                    endcase
                    fetch(r);
                end
                default: ;
            endcase
            r.fault = faulted;
            r.acc = acc;
            r.xr = xr;
            r.yr = yr;
            r.sp = sp;
            r.flags = flags;
            r.pc = pc;
            return r;
        endfunction

        function void note(input logic [7:0] rd);
            pending.push_back(step(rd));
        endfunction

        function void cmp(input string field, input logic [15:0] e, input logic [15:0] got);
            if (got !== e) begin
                errors++;
                $display("%0t: %s expected %h actual %h", $time, field, e, got);
            end
        endfunction

        function void check(input t_bus_cycle got);
            t_bus_cycle e;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t: bus request with none expected, address %h", $time, got.addr);
                return;
            end
            e = pending.pop_front();
            cmp("bus_address", e.addr, got.addr);
            cmp("bus_write", 16'(e.wr), 16'(got.wr));
            cmp("bus_write_data", 16'(e.wdata), 16'(got.wdata));
            cmp("instr_done", 16'(e.done), 16'(got.done));
            cmp("fault", 16'(e.fault), 16'(got.fault));
            cmp("acc_out", 16'(e.acc), 16'(got.acc));
            cmp("x_out", 16'(e.xr), 16'(got.xr));
            cmp("y_out", 16'(e.yr), 16'(got.yr));
            cmp("sp_out", 16'(e.sp), 16'(got.sp));
            cmp("flags_out", 16'(e.flags), 16'(got.flags));
            cmp("pc_out", e.pc, got.pc);
        endfunction

        function void leftovers();
            if (pending.size() != 0) begin
                errors += pending.size();
                $display("%0t: %0d bus requests never issued", $time, pending.size());
            end
        endfunction
    endclass

    // DUT signals, all inputs known from time zero
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index = CFG_START_PC;
    logic [15:0] i_cfg_data = '0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_read_data = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [15:0] o_bus_address;
    logic        o_bus_write;
    logic [7:0]  o_bus_write_data;
    logic        o_instr_done;
    logic        o_fault;
    logic [7:0]  o_acc_out;
    logic [7:0]  o_x_out;
    logic [7:0]  o_y_out;
    logic [7:0]  o_sp_out;
    logic [7:0]  o_flags_out;
    logic [15:0] o_pc_out;

    core_scoreboard sb = new();

    int items_sent = 0;   // items accepted so far
    int burst_left = 1;   // items left in the current sender burst

    // receiver pattern state
    int hold_cnt = 0;
    int seg_left = 0;
    int stall_pct = 0;
    bit held_once = 1'b0;

    cpu_load_store_transfer_core u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_read_data      (i_read_data),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_bus_address    (o_bus_address),
        .o_bus_write      (o_bus_write),
        .o_bus_write_data (o_bus_write_data),
        .o_instr_done     (o_instr_done),
        .o_fault          (o_fault),
        .o_acc_out        (o_acc_out),
        .o_x_out          (o_x_out),
        .o_y_out          (o_y_out),
        .o_sp_out         (o_sp_out),
        .o_flags_out      (o_flags_out),
        .o_pc_out         (o_pc_out)
    );

    // 20 ns clock
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Register write; valid is left high so back-to-back writes need one assignment per edge.
    // The caller lowers it after the last write.
    task automatic cfg_write(input logic idx, input logic [15:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (idx == CFG_START_PC) begin
            sb.start_pc = val;
        end else begin
            sb.undef_nop = val[0];
        end
    endtask

    task automatic configure(input logic [15:0] pc_val, input logic nop_val);
        cfg_write(CFG_START_PC, pc_val);
        cfg_write(CFG_UNDEF_NOP, {15'h0000, nop_val});
        i_cfg_valid <= 1'b0;
    endtask

    // Offer one bus-cycle item; at the end of a burst the sender drops valid for a
    // random gap (sometimes none).
    task automatic feed(input logic [7:0] d);
        int gap;
        i_in_valid <= 1'b1;
        i_read_data <= d;
        do @(posedge i_clk); while (o_in_stall);
        sb.note(d);
        items_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Stop offering and wait for every outstanding bus request; spare edges
    // after that leave the core idle.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    // Next read_data byte: a defined opcode when the core is waiting for one
    // (now and then any byte if undefined opcodes run as NOP), else operands
    // biased to the extremes.
    function automatic logic [7:0] next_byte();
        logic [7:0] b;
        t_dec       d;
        if (sb.ph == PH_OPCODE) begin
            if (sb.undef_nop && $urandom_range(0, 7) == 0) begin
                b = 8'($urandom_range(0, 255));
                return b;
            end
            do begin
                b = 8'($urandom_range(0, 255));
                d = sb.decode(b);
            end while (d.kind == K_BAD);
            return b;
        end
        case ($urandom_range(0, 7))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            2:       b = 8'h80;
            3:       b = 8'h7F;
            default: b = 8'($urandom_range(0, 255));
        endcase
        return b;
    endfunction

    function automatic logic [7:0] undefined_byte();
        logic [7:0] b;
        t_dec       d;
        do begin
            b = 8'($urandom_range(0, 255));
            d = sb.decode(b);
        end while (d.kind != K_BAD);
        return b;
    endfunction

    // Receiver: segments of differing stall density, including none, and one long
    // hold-off once traffic is flowing so the core backs up into its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            i_out_stall <= 1'b1;
        end else if (!held_once && items_sent >= 150) begin
            held_once = 1'b1;
            hold_cnt = 80;
            i_out_stall <= 1'b1;
        end else begin
            if (seg_left == 0) begin
                seg_left = $urandom_range(5, 40);
                case ($urandom_range(0, 3))
                    0:       stall_pct = 0;
                    1:       stall_pct = 20;
                    2:       stall_pct = 50;
                    default: stall_pct = 80;
                endcase
            end
            seg_left--;
            i_out_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    // Every accepted bus request is checked against the shadow CPU
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check('{o_bus_address, o_bus_write, o_bus_write_data, o_instr_done, o_fault,
                       o_acc_out, o_x_out, o_y_out, o_sp_out, o_flags_out, o_pc_out});
        end
    end

    // Main sequence
    initial begin
        // Loads of the extremes, every transfer, indexed and indirect wrap. Start at
        // FFFF so the PC wraps on the first fetch.
        logic [7:0] dir_a [] = '{
            8'h5A,                                   // first item after reset: ignored
            OP_LDA_IMM, 8'h00,                       // Z set
            OP_LDX_IMM, 8'hFF,                       // N set
            OP_LDY_IMM, 8'h80,
            OP_TXS, OP_TAX, OP_TSX, OP_TYA, OP_TAY, OP_TXA,
            OP_STA_ABSX, 8'hFF, 8'hFF, 8'h00,        // FFFF + X wraps past 64k
            OP_LDA_INDX, 8'h00, 8'h34, 8'h12, 8'h7F, // pointer 00 + FF stays in page zero
            OP_STX_ZPY, 8'hC0, 8'h00,                // zero-page index wraps
            OP_STA_INDY, 8'hFF, 8'hF0, 8'hFF, 8'h00  // pointer high from 00, address wraps
        };
        // Undefined opcodes run as NOP, then a zero-page indexed load
        logic [7:0] dir_b [] = '{
            OP_BRK, OP_CMP_IMM, OP_NOP, OP_UNUSED_FF,
            OP_LDA_ZPX, 8'hFF, 8'h00
        };
        int seg;
        int n;
        int w;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        cfg_write(CFG_START_PC, 16'h0000);
        configure(16'hFFFF, 1'b0);
        foreach (dir_a[k]) feed(dir_a[k]);

        drain();
        configure(16'($urandom_range(0, 65535)), 1'b1);
        foreach (dir_b[k]) feed(dir_b[k]);

        // Random programs, alternating NOP and fault handling of undefined opcodes
        for (seg = 0; seg < 6; seg++) begin
            drain();
            configure((seg == 1) ? 16'h0000 : 16'($urandom_range(0, 65535)), ~seg[0]);
            for (n = 0; n < 100; n++) begin
                if (seg == 2 && n == 50) begin
                    drain();   // sender holds until the core has answered everything
                end
                feed(next_byte());
            end
        end

        // Finally an undefined opcode with faults enabled; the core halts for good
        drain();
        configure(16'hFFFF, 1'b0);
        while (sb.ph != PH_OPCODE) feed(next_byte());
        feed(undefined_byte());
        repeat (12) feed(8'($urandom_range(0, 255)));

        i_in_valid <= 1'b0;
        for (w = 0; w < 1000 && sb.pending.size() != 0; w++) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        sb.leftovers();
        if (sb.errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Hang guard, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("%0t: timeout", $time);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/clst_pkg.sv
rtl/clst_decode.sv
rtl/cpu_load_store_transfer_core.sv
verif/tb_top.sv
